// File: sv/mocap_frame_body_extractor_macros.svh
// Assertion helpers for the frame body extractor.
`ifndef MOCAP_FRAME_BODY_EXTRACTOR_MACROS_SVH
`define MOCAP_FRAME_BODY_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MFBE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MFBE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mfbe_pkg.sv
package mfbe_pkg;

	localparam int          MAX_BODIES_DEF = 128;
	localparam logic [15:0] FRAME_MSG_ID   = 16'd7;
	localparam logic [31:0] MARKER_BYTES   = 32'd12;
	localparam int          BODY_WORDS     = 8;
	localparam int          BW_IDX_W       = $clog2(BODY_WORDS);
	localparam int          POSE_WORDS     = 7;
	localparam int          FIFO_DEPTH     = 4;
	localparam logic [31:0] TARGET_RESET   = 32'd1;
	localparam int          REG_IDX_W      = 1;
	localparam logic [REG_IDX_W-1:0] REG_TARGET = 1'b0;

	typedef enum logic [3:0] {
		PH_MSGID  = 4'd0,
		PH_NBYTES = 4'd1,
		PH_FRAME  = 4'd2,
		PH_NSETS  = 4'd3,
		PH_NAME   = 4'd4,
		PH_NMARK  = 4'd5,
		PH_MARK   = 4'd6,
		PH_NOTHER = 4'd7,
		PH_OTHER  = 4'd8,
		PH_NBODY  = 4'd9,
		PH_BODY   = 4'd10,
		PH_IDLE   = 4'd11
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FRAME    = 2'd0,
		KIND_POSE     = 2'd1,
		KIND_OVERFLOW = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
	} item_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic signed [31:0] frame_count;
		logic [31:0]        pos_x;
		logic [31:0]        pos_y;
		logic [31:0]        pos_z;
		logic [31:0]        quat_w;
		logic [31:0]        quat_x;
		logic [31:0]        quat_y;
		logic [31:0]        quat_z;
	} result_t;

	// raw body words p1 p2 p3 q1 q2 q3 q4, zero for non-pose records
	typedef struct packed {
		kind_t                             kind;
		logic [31:0]                       frame;
		logic [POSE_WORDS-1:0][31:0]       words;
	} rec_t;

endpackage

// File: sv/mfbe_parser.sv
`include "mocap_frame_body_extractor_macros.svh"

module mfbe_parser #(
	parameter int MAX_BODIES = mfbe_pkg::MAX_BODIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  mfbe_pkg::item_t      item,
	input  logic signed [31:0]   target_body_id,
	output logic                 rec_push,
	output mfbe_pkg::rec_t       rec
);
	import mfbe_pkg::*;

	localparam int BCW = $clog2(MAX_BODIES + 1);

	phase_t           phase_q, phase_d, phase;
	logic [1:0]       biw_q, biw_d, biw;
	logic [31:0]      wa_q, wa_d;
	logic [15:0]      msg_kind_q, msg_kind_d;
	logic [31:0]      frame_q, frame_d;
	logic [31:0]      set_cnt_q, set_cnt_d, set_dec;
	logic [31:0]      item_cnt_q, item_cnt_d, item_dec;
	logic [BCW-1:0]   body_left_q, body_left_d, body_dec;
	logic [31:0]      body_words_q [BODY_WORDS];
	logic             bw_we;
	logic [BW_IDX_W-1:0] bw_idx;
	logic [31:0]      asm_w, wa_inc;
	logic             col_done, asm_pos;
	logic [1:0]       biw_col;
	logic [7:0]       b;

	always_comb begin
		b       = item.data_byte;
		phase   = (item.packet_start) ? PH_MSGID : phase_q;
		biw     = (item.packet_start) ? 2'd0 : biw_q;
		asm_w   = ((biw == 2'd0) ? 32'd0 : wa_q) | (32'(b) << {biw, 3'b000});
		col_done = (phase == PH_MSGID || phase == PH_NBYTES) ? (biw != 2'd0)
		                                                     : (biw == 2'd3);
		biw_col = col_done ? 2'd0 : biw + 2'd1;
		asm_pos = (asm_w != 32'd0) && !asm_w[31];
		wa_inc  = wa_q + 32'd1;
		set_dec = (set_cnt_q != 32'd0) ? set_cnt_q - 32'd1 : set_cnt_q;
		item_dec = item_cnt_q - 32'd1;
		body_dec = body_left_q - BCW'(1);

		phase_d     = phase_q;
		biw_d       = biw_q;
		wa_d        = wa_q;
		msg_kind_d  = msg_kind_q;
		frame_d     = frame_q;
		set_cnt_d   = set_cnt_q;
		item_cnt_d  = item_cnt_q;
		body_left_d = body_left_q;
		bw_we       = 1'b0;
		bw_idx      = set_cnt_q[BW_IDX_W-1:0];
		rec_push    = 1'b0;
		rec.kind    = KIND_FRAME;
		rec.frame   = frame_q;
		rec.words   = '0;

		if (take) begin
			phase_d = phase;
			biw_d   = biw;
			unique case (phase)
				PH_MSGID: begin
					wa_d  = asm_w;
					biw_d = biw_col;
					if (col_done) begin
						msg_kind_d = asm_w[15:0];
						phase_d    = PH_NBYTES;
					end
				end
				PH_NBYTES: begin
					wa_d  = asm_w;
					biw_d = biw_col;
					if (col_done)
						phase_d = (msg_kind_q == FRAME_MSG_ID) ? PH_FRAME : PH_IDLE;
				end
				PH_FRAME: begin
					wa_d  = asm_w;
					biw_d = biw_col;
					if (col_done) begin
						frame_d   = asm_w;
						phase_d   = PH_NSETS;
						rec_push  = 1'b1;
						rec.kind  = KIND_FRAME;
						rec.frame = asm_w;
					end
				end
				PH_NSETS: begin
					wa_d  = asm_w;
					biw_d = biw_col;
					if (col_done) begin
						if (asm_pos) begin
							set_cnt_d = asm_w;
							phase_d   = PH_NAME;
						end else begin
							phase_d = PH_NOTHER;
						end
					end
				end
				PH_NAME: begin
					if (b == 8'd0) begin
						biw_d   = 2'd0;
						phase_d = PH_NMARK;
					end
				end
				PH_NMARK: begin
					wa_d  = asm_w;
					biw_d = biw_col;
					if (col_done) begin
						if (asm_pos) begin
							item_cnt_d = asm_w;
							wa_d       = 32'd0;
							phase_d    = PH_MARK;
						end else begin
							set_cnt_d = set_dec;
							phase_d   = (set_dec != 32'd0) ? PH_NAME : PH_NOTHER;
						end
					end
				end
				PH_MARK, PH_OTHER: begin
					wa_d = wa_inc;
					if (wa_inc >= MARKER_BYTES) begin
						wa_d       = 32'd0;
						item_cnt_d = item_dec;
						if (item_dec == 32'd0) begin
							if (phase == PH_MARK) begin
								set_cnt_d = set_dec;
								phase_d   = (set_dec != 32'd0) ? PH_NAME : PH_NOTHER;
							end else begin
								phase_d = PH_NBODY;
							end
						end
					end
				end
				PH_NOTHER: begin
					wa_d  = asm_w;
					biw_d = biw_col;
					if (col_done) begin
						if (asm_pos) begin
							item_cnt_d = asm_w;
							wa_d       = 32'd0;
							phase_d    = PH_OTHER;
						end else begin
							phase_d = PH_NBODY;
						end
					end
				end
				PH_NBODY: begin
					wa_d  = asm_w;
					biw_d = biw_col;
					if (col_done) begin
						if (!asm_pos) begin
							phase_d = PH_IDLE;
						end else if (asm_w > 32'(MAX_BODIES)) begin
							phase_d  = PH_IDLE;
							rec_push = 1'b1;
							rec.kind = KIND_OVERFLOW;
						end else begin
							body_left_d = asm_w[BCW-1:0];
							set_cnt_d   = 32'd0;
							phase_d     = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					wa_d  = asm_w;
					biw_d = biw_col;
					if (col_done) begin
						bw_we     = 1'b1;
						set_cnt_d = set_cnt_q + 32'd1;
						if (set_cnt_q[BW_IDX_W-1:0] == BW_IDX_W'(BODY_WORDS - 1)) begin
							set_cnt_d   = 32'd0;
							body_left_d = body_dec;
							if (body_dec == '0)
								phase_d = PH_IDLE;
							if (body_words_q[0] == $unsigned(target_body_id)) begin
								rec_push  = 1'b1;
								rec.kind  = KIND_POSE;
								rec.words = {asm_w, body_words_q[6], body_words_q[5],
								             body_words_q[4], body_words_q[3],
								             body_words_q[2], body_words_q[1]};
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MSGID;
			biw_q       <= 2'd0;
			wa_q        <= 32'd0;
			msg_kind_q  <= 16'd0;
			frame_q     <= 32'd0;
			set_cnt_q   <= 32'd0;
			item_cnt_q  <= 32'd0;
			body_left_q <= '0;
		end else begin
			phase_q     <= phase_d;
			biw_q       <= biw_d;
			wa_q        <= wa_d;
			msg_kind_q  <= msg_kind_d;
			frame_q     <= frame_d;
			set_cnt_q   <= set_cnt_d;
			item_cnt_q  <= item_cnt_d;
			body_left_q <= body_left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (bw_we)
			body_words_q[bw_idx] <= asm_w;
	end

	`MFBE_ASSERT_IMP(a_push_on_take, rec_push, take, "record without accepted byte")
	`MFBE_ASSERT_NXT(a_restart, take && item.packet_start,
		phase_q == PH_MSGID && biw_q == 2'd1, "packet start did not restart parse")
	`MFBE_ASSERT_IMP(a_mark_aligned, phase_q == PH_MARK || phase_q == PH_OTHER,
		biw_q == 2'd0, "marker skip entered mid-word")

endmodule

// File: sv/mfbe_fifo.sv
`include "mocap_frame_body_extractor_macros.svh"

module mfbe_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mfbe_pkg::rec_t  wr_rec,
	output logic            full,
	input  logic            pop,
	output logic            fifo_empty,
	output mfbe_pkg::rec_t  rd_rec
);
	import mfbe_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	rec_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_en, pop_en;

	assign full       = (count_q == CNT_W'(FIFO_DEPTH));
	assign fifo_empty = (count_q == '0);
	assign push_en    = push && !full;
	assign pop_en     = pop && !fifo_empty;
	assign rd_rec     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_en)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop_en)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push_en && !pop_en)
				count_q <= count_q + CNT_W'(1);
			else if (pop_en && !push_en)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push_en)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	`MFBE_ASSERT_IMP(a_cnt_bound, 1'b1, count_q <= CNT_W'(FIFO_DEPTH), "queue overfilled")
	`MFBE_ASSERT_NXT(a_cnt_up, push_en && !pop_en,
		count_q == $past(count_q) + CNT_W'(1), "push lost")
	`MFBE_ASSERT_NXT(a_cnt_dn, pop_en && !push_en,
		count_q == $past(count_q) - CNT_W'(1), "pop lost")

endmodule

// File: sv/mfbe_back.sv
module mfbe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fifo_empty,
	input  mfbe_pkg::rec_t    rd_rec,
	output logic              fifo_pop,
	input  logic              pop,
	output logic              empty,
	output mfbe_pkg::result_t result
);
	import mfbe_pkg::*;

	logic    valid_q;
	result_t out_q, fmt;

	always_comb begin
		fmt.result_kind = rd_rec.kind;
		fmt.frame_count = rd_rec.frame;
		fmt.pos_x       = rd_rec.words[2];
		fmt.pos_y       = rd_rec.words[0];
		fmt.pos_z       = rd_rec.words[1];
		fmt.quat_w      = rd_rec.words[6];
		fmt.quat_x      = rd_rec.words[3];
		fmt.quat_y      = rd_rec.words[5];
		fmt.quat_z      = rd_rec.words[4];
		// z axis flips sign, only meaningful for poses
		if (rd_rec.kind == KIND_POSE)
			fmt.pos_z = rd_rec.words[1] ^ 32'h8000_0000;
	end

	assign fifo_pop = !fifo_empty && (!valid_q || pop);
	assign empty    = !valid_q;
	assign result   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fifo_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop)
			out_q <= fmt;
	end

endmodule

// File: sv/mocap_frame_body_extractor.sv
// Motion-capture frame parser: takes one packet byte per cycle (push while
// full is low, packet_start on the first byte) and reports the frame number,
// the pose of the rigid body whose id matches target_body_id, or a
// too-many-bodies error. A byte is parsed in the cycle it is accepted; any
// result enters a 4-entry queue and then the output register, and only then
// shows on result. Bytes flow at one per cycle as long as results are popped;
// full rises only when the result queue holds four entries.
module mocap_frame_body_extractor #(
	parameter int MAX_BODIES = mfbe_pkg::MAX_BODIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  mfbe_pkg::item_t               item,
	output logic                          empty,
	input  logic                          pop,
	output mfbe_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mfbe_pkg::REG_IDX_W+1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import mfbe_pkg::*;

	logic signed [31:0] target_q;
	logic               take, rec_push, fifo_empty, fifo_pop;
	rec_t               rec, rd_rec;
	logic [REG_IDX_W-1:0] reg_idx;

	assign reg_idx = paddr[REG_IDX_W+1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_TARGET) ? target_q : 32'd0;
	assign take    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (psel && penable && pwrite && reg_idx == REG_TARGET) begin
			target_q <= pwdata;
		end
	end

	mfbe_parser #(
		.MAX_BODIES(MAX_BODIES)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.item          (item),
		.target_body_id(target_q),
		.rec_push      (rec_push),
		.rec           (rec)
	);

	mfbe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.wr_rec    (rec),
		.full      (full),
		.pop       (fifo_pop),
		.fifo_empty(fifo_empty),
		.rd_rec    (rd_rec)
	);

	mfbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_empty(fifo_empty),
		.rd_rec    (rd_rec),
		.fifo_pop  (fifo_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// File: bench/mfbe_frame_checker.sv
module mfbe_frame_checker #(
	parameter int MAX_BODIES = mfbe_pkg::MAX_BODIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  mfbe_pkg::item_t                item,
	input  logic                           empty,
	input  logic                           pop,
	input  mfbe_pkg::result_t              result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [mfbe_pkg::REG_IDX_W+1:0] paddr,
	input  logic [31:0]                    pwdata,
	output int                             errors,
	output int                             owed
);
	import mfbe_pkg::*;

	phase_t      phase;
	logic [1:0]  byte_idx;
	logic [31:0] word_acc;
	logic [15:0] msg_id;
	logic [31:0] frame_reg;
	logic [31:0] set_cnt;
	logic [31:0] item_cnt;
	logic [31:0] target;
	logic [31:0] body [BODY_WORDS];
	result_t     frame_reports [$];

	task automatic report_bad(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mfbe_frame_checker: %0t %s: got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	// little-endian word assembly, true once nbytes are in
	function automatic bit collect(input logic [7:0] b, input int nbytes);
		if (byte_idx == 2'd0) word_acc = '0;
		word_acc = word_acc | (32'(b) << (8 * byte_idx));
		if (int'(byte_idx) + 1 >= nbytes) begin
			byte_idx = 2'd0;
			return 1'b1;
		end
		byte_idx = byte_idx + 2'd1;
		return 1'b0;
	endfunction

	function automatic bit positive(input logic [31:0] w);
		return w != '0 && !w[31];
	endfunction

	function automatic void log_record(input kind_t k, input bit pose);
		result_t r;
		r = '0;
		r.result_kind = k;
		r.frame_count = frame_reg;
		if (pose) begin
			r.pos_x  = body[3];
			r.pos_y  = body[1];
			r.pos_z  = body[2] ^ 32'h8000_0000;
			r.quat_w = body[7];
			r.quat_x = body[4];
			r.quat_y = body[6];
			r.quat_z = body[5];
		end
		frame_reports.push_back(r);
	endfunction

	function automatic void next_set();
		if (set_cnt > 0) set_cnt = set_cnt - 1;
		phase = (set_cnt > 0) ? PH_NAME : PH_NOTHER;
	endfunction

	task automatic parse_byte(input item_t it);
		logic [7:0] b;
		bit         hit;
		b = it.data_byte;
		if (it.packet_start) begin
			phase    = PH_MSGID;
			byte_idx = 2'd0;
		end
		case (phase)
			PH_MSGID: begin
				if (collect(b, 2)) begin
					msg_id = word_acc[15:0];
					phase  = PH_NBYTES;
				end
			end
			PH_NBYTES: begin
				if (collect(b, 2)) phase = (msg_id == FRAME_MSG_ID) ? PH_FRAME : PH_IDLE;
			end
			PH_FRAME: begin
				if (collect(b, 4)) begin
					frame_reg = word_acc;
					phase     = PH_NSETS;
					log_record(KIND_FRAME, 1'b0);
				end
			end
			PH_NSETS: begin
				if (collect(b, 4)) begin
					if (positive(word_acc)) begin
						set_cnt = word_acc;
						phase   = PH_NAME;
					end else begin
						phase = PH_NOTHER;
					end
				end
			end
			PH_NAME: begin
				if (b == 8'h00) begin
					byte_idx = 2'd0;
					phase    = PH_NMARK;
				end
			end
			PH_NMARK: begin
				if (collect(b, 4)) begin
					if (positive(word_acc)) begin
						item_cnt = word_acc;
						word_acc = '0;
						phase    = PH_MARK;
					end else begin
						next_set();
					end
				end
			end
			PH_MARK, PH_OTHER: begin
				word_acc = word_acc + 1;
				if (word_acc >= MARKER_BYTES) begin
					word_acc = '0;
					item_cnt = item_cnt - 1;
					if (item_cnt == 0) begin
						if (phase == PH_MARK) next_set();
						else phase = PH_NBODY;
					end
				end
			end
			PH_NOTHER: begin
				if (collect(b, 4)) begin
					if (positive(word_acc)) begin
						item_cnt = word_acc;
						word_acc = '0;
						phase    = PH_OTHER;
					end else begin
						phase = PH_NBODY;
					end
				end
			end
			PH_NBODY: begin
				if (collect(b, 4)) begin
					if (!positive(word_acc)) begin
						phase = PH_IDLE;
					end else if (word_acc > 32'(MAX_BODIES)) begin
						phase = PH_IDLE;
						log_record(KIND_OVERFLOW, 1'b0);
					end else begin
						item_cnt = word_acc;
						set_cnt  = '0;
						phase    = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (collect(b, 4)) begin
					body[set_cnt[BW_IDX_W-1:0]] = word_acc;
					set_cnt = set_cnt + 1;
					if (set_cnt >= BODY_WORDS) begin
						hit      = (body[0] == target);
						set_cnt  = '0;
						item_cnt = item_cnt - 1;
						if (item_cnt == 0) phase = PH_IDLE;
						if (hit) log_record(KIND_POSE, 1'b1);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_record(input result_t got);
		result_t want;
		if (frame_reports.size() == 0) begin
			report_bad("transfer with nothing owed, frame", got.frame_count, '0);
			return;
		end
		want = frame_reports.pop_front();
		if (got.result_kind !== want.result_kind)
			report_bad("result_kind", 32'(got.result_kind), 32'(want.result_kind));
		if (got.frame_count !== want.frame_count)
			report_bad("frame_count", got.frame_count, want.frame_count);
		if (got.pos_x !== want.pos_x) report_bad("pos_x", got.pos_x, want.pos_x);
		if (got.pos_y !== want.pos_y) report_bad("pos_y", got.pos_y, want.pos_y);
		if (got.pos_z !== want.pos_z) report_bad("pos_z", got.pos_z, want.pos_z);
		if (got.quat_w !== want.quat_w) report_bad("quat_w", got.quat_w, want.quat_w);
		if (got.quat_x !== want.quat_x) report_bad("quat_x", got.quat_x, want.quat_x);
		if (got.quat_y !== want.quat_y) report_bad("quat_y", got.quat_y, want.quat_y);
		if (got.quat_z !== want.quat_z) report_bad("quat_z", got.quat_z, want.quat_z);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase     = PH_MSGID;
			byte_idx  = 2'd0;
			word_acc  = '0;
			msg_id    = '0;
			frame_reg = '0;
			set_cnt   = '0;
			item_cnt  = '0;
			target    = TARGET_RESET;
			frame_reports.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == {REG_TARGET, 2'b00})
				target = pwdata;
			if (push && !full) parse_byte(item);
			if (pop && !empty) check_record(result);
		end
		owed = frame_reports.size();
	end

endmodule

// File: bench/tb_mocap_frame_body_extractor.sv
module tb_mocap_frame_body_extractor;
	import mfbe_pkg::*;

	localparam int LIMIT    = 300000;
	localparam int HOLD_LEN = 600;
	localparam int SETTLE   = 10;
	localparam int WHOLE    = 1 << 30;

	logic                 clk     = 1'b0;
	logic                 arst_n  = 1'b0;
	logic                 push    = 1'b0;
	logic                 pop     = 1'b0;
	item_t                item    = '0;
	logic                 psel    = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite  = 1'b0;
	logic [REG_IDX_W+1:0] paddr   = '0;
	logic [31:0]          pwdata  = '0;
	logic                 full;
	logic                 empty;
	logic                 pready;
	logic [31:0]          prdata;
	result_t              result;

	int errors;
	int owed;

	int          idle_pct   = 0;
	int          stall_pct  = 0;
	int          hold_reqs  = 0;
	int          hold_taken = 0;
	int          hold_left  = 0;
	logic [31:0] cur_target = TARGET_RESET;
	logic [7:0]  pkt [$];
	item_t       byte_q [$];

	mocap_frame_body_extractor u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mfbe_frame_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.errors   (errors),
		.owed     (owed)
	);

	always #5 clk = ~clk;

	// receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left == 0 && hold_reqs != hold_taken) begin
			hold_taken = hold_reqs;
			hold_left  = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop = 1'b0;
		end else begin
			pop = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("tb_mocap_frame_body_extractor: done, errors");
		$finish;
	end

	function automatic int live(input logic [31:0] v);
		return (v != '0 && !v[31]) ? int'(v) : 0;
	endfunction

	function automatic logic [31:0] rand_count(input int hi);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {1'b1, 31'($urandom)};
			default: return $urandom_range(1, hi);
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_id();
		case ($urandom_range(0, 3))
			0, 1: return cur_target;
			2: return cur_target ^ (32'h1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	task automatic put16(input logic [15:0] v);
		pkt.push_back(v[7:0]);
		pkt.push_back(v[15:8]);
	endtask

	task automatic put32(input logic [31:0] v);
		for (int i = 0; i < 4; i++) pkt.push_back(v[8*i +: 8]);
	endtask

	task automatic put_body(input logic [31:0] id);
		put32(id);
		repeat (7) put32(rand_word());
	endtask

	task automatic commit(input int upto);
		item_t b;
		for (int i = 0; i < pkt.size() && i < upto; i++) begin
			b.data_byte    = pkt[i];
			b.packet_start = (i == 0);
			byte_q.push_back(b);
		end
		pkt.delete();
	endtask

	task automatic add_loose(input int n, input int start_pct);
		item_t b;
		repeat (n) begin
			b.data_byte    = 8'($urandom);
			b.packet_start = ($urandom_range(0, 99) < start_pct);
			byte_q.push_back(b);
		end
	endtask

	task automatic gen_frame(input int bodies, input bit overflow, input bit all_hit);
		logic [31:0] cnt;
		int          n;
		int          len;
		put16(FRAME_MSG_ID);
		put16(16'($urandom));
		put32($urandom);
		cnt = rand_count(2);
		put32(cnt);
		n = live(cnt);
		repeat (n) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 5);
			repeat (len) pkt.push_back(8'($urandom_range(1, 255)));
			pkt.push_back(8'h00);
			cnt = rand_count(3);
			put32(cnt);
			repeat (12 * live(cnt)) pkt.push_back(8'($urandom));
		end
		cnt = rand_count(2);
		put32(cnt);
		repeat (12 * live(cnt)) pkt.push_back(8'($urandom));
		if (overflow) begin
			put32(($urandom_range(0, 1) == 1) ? 32'(MAX_BODIES_DEF + 1) :
				$urandom_range(MAX_BODIES_DEF + 2, 32'h7FFF_FFFF));
			repeat ($urandom_range(0, 8)) pkt.push_back(8'($urandom));
		end else begin
			cnt = (bodies >= 0) ? 32'(bodies) : rand_count(4);
			put32(cnt);
			repeat (live(cnt)) put_body(all_hit ? cur_target : pick_id());
		end
	endtask

	task automatic gen_packet();
		logic [15:0] id;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			gen_frame(-1, 1'b0, 1'b0);
			commit(WHOLE);
			if ($urandom_range(0, 4) == 0) add_loose($urandom_range(1, 8), 0);
		end else if (r < 77) begin
			gen_frame(-1, 1'b0, 1'b0);
			commit($urandom_range(1, pkt.size() - 1));
		end else if (r < 87) begin
			id = 16'($urandom);
			if (id == FRAME_MSG_ID) id = ~id;
			put16(id);
			put16(16'($urandom));
			repeat ($urandom_range(0, 12)) pkt.push_back(8'($urandom));
			commit(WHOLE);
		end else if (r < 95) begin
			gen_frame(-1, 1'b1, 1'b0);
			commit(WHOLE);
		end else begin
			add_loose($urandom_range(1, 10), 25);
		end
	endtask

	task automatic send_all();
		while (byte_q.size() > 0) begin
			@(negedge clk);
			if ($urandom_range(0, 99) < idle_pct) begin
				push = 1'b0;
			end else begin
				push = 1'b1;
				item = byte_q[0];
			end
			@(posedge clk);
			if (push && !full) void'(byte_q.pop_front());
		end
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic settle();
		while (owed != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_target(input logic [31:0] v);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {REG_TARGET, 2'b00};
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		cur_target = v;
	endtask

	task automatic run_phase(input logic [31:0] tgt, input int idle, input int stall,
			input int min_bytes, input bit hold);
		int sent;
		settle();
		write_target(tgt);
		idle_pct  = idle;
		stall_pct = stall;
		sent      = 0;
		if (hold) begin
			// receiver blocks while a dense packet goes in, so full must rise
			hold_reqs++;
			gen_frame(5, 1'b0, 1'b1);
			commit(WHOLE);
			sent += byte_q.size();
			send_all();
		end
		while (sent < min_bytes) begin
			gen_packet();
			sent += byte_q.size();
			send_all();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// not a frame: low id byte matches, high byte does not
		put16(16'h0107);
		put16(16'hFFFF);
		pkt.push_back(8'h07);
		commit(WHOLE);
		// all counts zero, then bytes past the end
		put16(FRAME_MSG_ID);
		put16(16'h0000);
		put32(32'h8000_0000);
		put32('0);
		put32('0);
		put32('0);
		commit(WHOLE);
		add_loose(3, 0);
		// negative counts
		put16(FRAME_MSG_ID);
		put16(16'hFFFF);
		put32(32'h7FFF_FFFF);
		put32('1);
		put32(32'h8000_0000);
		put32('1);
		commit(WHOLE);
		// long name, one marker, one loose marker, target hit then miss
		put16(FRAME_MSG_ID);
		put16(16'd100);
		put32('1);
		put32(32'd1);
		repeat (30) pkt.push_back(8'hFF);
		pkt.push_back(8'h00);
		put32(32'd1);
		repeat (12) pkt.push_back(8'h00);
		put32(32'd1);
		repeat (12) pkt.push_back(8'hFF);
		put32(32'd2);
		put32(TARGET_RESET);
		put32('0);
		put32('1);
		put32(32'h8000_0000);
		put32(32'h7FFF_FFFF);
		put32(32'h0000_0001);
		put32(32'hFFFF_FFFE);
		put32(32'h8000_0001);
		put_body(TARGET_RESET + 1);
		commit(WHOLE);
		// too many bodies
		put16(FRAME_MSG_ID);
		put16(16'h0000);
		put32(32'd5);
		put32('0);
		put32('0);
		put32(32'(MAX_BODIES_DEF + 1));
		repeat (4) pkt.push_back(8'($urandom));
		commit(WHOLE);
		// exactly the maximum, cut short after one body
		put16(FRAME_MSG_ID);
		put16(16'h0000);
		put32(32'd6);
		put32('0);
		put32('0);
		put32(32'(MAX_BODIES_DEF));
		put_body(TARGET_RESET);
		commit(WHOLE);
		// cut inside the frame number, then a clean packet
		put16(FRAME_MSG_ID);
		put16(16'h0000);
		put32(32'h0102_0304);
		commit(7);
		put16(FRAME_MSG_ID);
		put16(16'h0000);
		put32(32'd8);
		put32('0);
		put32('0);
		put32(32'd1);
		put_body(TARGET_RESET);
		commit(WHOLE);
		send_all();

		run_phase(32'h7FFF_FFFF, 0, 0, 80, 1'b0);
		run_phase(32'h8000_0000, 64, 0, 80, 1'b0);
		run_phase(32'h0000_0000, 0, 64, 80, 1'b1);
		run_phase($urandom, 33, 33, 80, 1'b0);
		run_phase(32'hFFFF_FFFF, 0, 0, 80, 1'b1);

		settle();
		if (errors == 0) begin
			$display("tb_mocap_frame_body_extractor: done, clean");
		end else begin
			$display("tb_mocap_frame_body_extractor: done, errors");
		end
		$finish;
	end

endmodule
